// ===== rtl/avgp_pkg.sv =====
package avgp_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd0;
    localparam logic [2:0] CFG_WINDOW_LEN    = 3'd1;
    localparam logic [2:0] CFG_WINDOW_STEP   = 3'd2;
    localparam logic [2:0] CFG_RELU_ENABLE   = 3'd3;
    localparam logic [2:0] CFG_SCALE_SHIFT   = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // width of the pool size register, also the divisor width
    localparam int PW = 5;

    typedef struct packed {
        logic [6:0]        channel_count;
        logic [PW-1:0]     window_len;
        logic [7:0]        window_step;
        logic              relu_enable;
        logic signed [5:0] scale_shift;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic mem_rd;
        logic update;
        logic div_start;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic emit;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/avgp_div.sv =====
module avgp_div import avgp_pkg::*; #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ACC_WIDTH-1:0]        i_magnitude,
    input  logic                        i_negative,
    input  logic [PW-1:0]               i_divisor,
    output logic                        o_done,
    output logic signed [ACC_WIDTH-1:0] o_quotient
);

    localparam int CNT_W = $clog2(ACC_WIDTH + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [ACC_WIDTH-1:0]        r_quo;
    logic [PW-1:0]               r_rem;
    logic [PW-1:0]               r_dvs;
    logic                        r_neg;
    logic signed [ACC_WIDTH-1:0] r_res;

    logic [PW:0] w_trial;
    logic        w_fit;

    // one restoring step: bring down the next dividend bit
    assign w_trial = {r_rem, r_quo[ACC_WIDTH-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ACC_WIDTH);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_magnitude;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_neg <= i_negative;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_quo <= {r_quo[ACC_WIDTH-2:0], w_fit};
                r_rem <= w_fit ? PW'(w_trial - {1'b0, r_dvs}) : PW'(w_trial);
            end else begin
                r_res <= r_neg ? -$signed(r_quo) : $signed(r_quo);
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_res;

endmodule

// ===== rtl/avgp_dp.sv =====
module avgp_dp import avgp_pkg::*; #(
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_POOL     = 16,
    parameter int DATA_WIDTH   = 16,
    parameter int ACC_WIDTH    = 32,
    parameter int CH_W         = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  t_cmd                         i_cmd,
    output t_sts                         o_sts,
    input  logic signed [DATA_WIDTH-1:0] i_sample_value,
    input  logic                         i_frame_start,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_avg_value,
    output logic [15:0]                  o_out_position,
    output logic [CH_W-1:0]              o_out_channel
);

    localparam int SL_W = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int HDEPTH = MAX_CHANNELS * MAX_POOL;
    localparam int HA_W = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int FC_W = CH_W + 1;
    localparam int CW   = ACC_WIDTH + DATA_WIDTH;

    // storage
    logic signed [ACC_WIDTH-1:0]  r_sum_mem  [MAX_CHANNELS];
    logic signed [DATA_WIDTH-1:0] r_hist_mem [HDEPTH];

    logic signed [DATA_WIDTH-1:0] r_x;
    logic signed [ACC_WIDTH-1:0]  r_rd_sum;
    logic signed [DATA_WIDTH-1:0] r_rd_hist;
    logic signed [ACC_WIDTH-1:0]  r_sum;
    logic [CH_W-1:0]              r_chan;
    logic [SL_W-1:0]              r_slot;
    logic [15:0]                  r_sidx;
    logic [7:0]                   r_cd;
    logic [15:0]                  r_wc;
    logic [FC_W-1:0]              r_fill;
    logic [15:0]                  r_emit_pos;
    logic [CH_W-1:0]              r_emit_ch;

    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_avg;
    logic [15:0]                  r_pos;
    logic [CH_W-1:0]              r_ch;

    logic [31:0]                  w_nch;
    logic [31:0]                  w_p;
    logic [7:0]                   w_cd_reload;
    logic [HA_W-1:0]              w_haddr;
    logic                         w_sum_valid;
    logic                         w_window_full;
    logic                         w_window_done;
    logic signed [ACC_WIDTH-1:0]  w_old_sum;
    logic signed [ACC_WIDTH-1:0]  w_drop;
    logic signed [ACC_WIDTH-1:0]  w_new_sum;
    logic [31:0]                  w_chan_inc;
    logic [31:0]                  w_slot_inc;
    logic signed [ACC_WIDTH-1:0]  w_clamped;
    logic                         w_neg;
    logic [ACC_WIDTH-1:0]         w_mag;
    logic                         w_div_done;
    logic signed [ACC_WIDTH-1:0]  w_quo;
    logic signed [DATA_WIDTH-1:0] w_scaled;
    logic                         w_out_free;

    // effective configuration
    always_comb begin
        if (i_cfg.channel_count == '0) begin
            w_nch = 32'd1;
        end else if (32'(i_cfg.channel_count) > 32'(MAX_CHANNELS)) begin
            w_nch = 32'(MAX_CHANNELS);
        end else begin
            w_nch = 32'(i_cfg.channel_count);
        end
        if (i_cfg.window_len == '0) begin
            w_p = 32'd1;
        end else if (32'(i_cfg.window_len) > 32'(MAX_POOL)) begin
            w_p = 32'(MAX_POOL);
        end else begin
            w_p = 32'(i_cfg.window_len);
        end
        w_cd_reload = (i_cfg.window_step == '0) ? 8'd0 : i_cfg.window_step - 8'd1;
    end

    // window bookkeeping from the current counters
    assign w_haddr       = HA_W'(32'(r_chan) * 32'(MAX_POOL) + 32'(r_slot));
    assign w_sum_valid   = (FC_W'(r_chan) < r_fill);
    assign w_window_full = (32'(r_sidx) >= w_p);
    assign w_window_done = (32'(r_sidx) >= w_p - 32'd1);
    assign w_chan_inc    = 32'(r_chan) + 32'd1;
    assign w_slot_inc    = 32'(r_slot) + 32'd1;

    // running sum: add the new sample, drop the oldest once the window is full
    assign w_old_sum = w_sum_valid ? r_rd_sum : '0;
    assign w_drop    = w_window_full ? ACC_WIDTH'(r_rd_hist) : '0;
    assign w_new_sum = w_old_sum + ACC_WIDTH'(r_x) - w_drop;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x <= i_sample_value;
        end
    end

    // memory reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd_sum  <= r_sum_mem[r_chan];
            r_rd_hist <= r_hist_mem[w_haddr];
        end
    end

    // memory writes and sum capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_sum_mem[r_chan]   <= w_new_sum;
            r_hist_mem[w_haddr] <= r_x;
            r_sum               <= w_new_sum;
            r_emit_pos          <= r_wc;
            r_emit_ch           <= r_chan;
        end
    end

    // frame counters and sum fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
            r_slot <= '0;
            r_sidx <= '0;
            r_cd   <= '0;
            r_wc   <= '0;
            r_fill <= '0;
        end else if (i_cmd.load_in && i_frame_start) begin
            r_chan <= '0;
            r_slot <= '0;
            r_sidx <= '0;
            r_cd   <= '0;
            r_wc   <= '0;
            r_fill <= '0;
        end else if (i_cmd.update) begin
            if (!w_sum_valid) begin
                r_fill <= FC_W'(r_chan) + FC_W'(1);
            end
            if (w_chan_inc >= w_nch) begin
                r_chan <= '0;
                if (w_window_done) begin
                    if (r_cd == '0) begin
                        r_cd <= w_cd_reload;
                        r_wc <= r_wc + 16'd1;
                    end else begin
                        r_cd <= r_cd - 8'd1;
                    end
                end
                if (r_sidx != 16'hffff) begin
                    r_sidx <= r_sidx + 16'd1;
                end
                r_slot <= (w_slot_inc >= w_p) ? '0 : SL_W'(w_slot_inc);
            end else begin
                r_chan <= CH_W'(w_chan_inc);
            end
        end
    end

    // relu clamp and sign split for the divider
    assign w_clamped = (i_cfg.relu_enable && r_sum < 0) ? '0 : r_sum;
    assign w_neg     = w_clamped[ACC_WIDTH-1];
    assign w_mag     = w_neg ? ACC_WIDTH'(-w_clamped) : ACC_WIDTH'(w_clamped);

    avgp_div #(
        .ACC_WIDTH(ACC_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_magnitude(w_mag),
        .i_negative (w_neg),
        .i_divisor  (PW'(w_p)),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // rescale by the signed shift and saturate
    always_comb begin
        logic signed [CW-1:0] a_ext;
        logic signed [CW-1:0] hi;
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] hi_k;
        logic signed [CW-1:0] lim_k;
        logic signed [CW-1:0] shr;
        logic [5:0]           k;
        a_ext = CW'(w_quo);
        hi    = CW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
        lo    = -(hi + CW'(1));
        k     = 6'(-i_cfg.scale_shift);
        hi_k  = hi >>> k;
        lim_k = (hi + CW'(1)) >>> k;
        shr   = CW'(w_quo >>> $unsigned(i_cfg.scale_shift));
        if (i_cfg.scale_shift < 0) begin
            if (a_ext > hi_k) begin
                w_scaled = DATA_WIDTH'(hi);
            end else if (a_ext < -lim_k) begin
                w_scaled = DATA_WIDTH'(lo);
            end else begin
                w_scaled = DATA_WIDTH'(a_ext <<< k);
            end
        end else begin
            if (shr > hi) begin
                w_scaled = DATA_WIDTH'(hi);
            end else if (shr < lo) begin
                w_scaled = DATA_WIDTH'(lo);
            end else begin
                w_scaled = DATA_WIDTH'(shr);
            end
        end
    end

    // output register
    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_avg <= w_scaled;
            r_pos <= r_emit_pos;
            r_ch  <= r_emit_ch;
        end
    end

    // status
    assign o_sts.emit     = w_window_done && (r_cd == '0);
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = w_out_free;

    assign o_valid        = r_out_valid;
    assign o_avg_value    = r_avg;
    assign o_out_position = r_pos;
    assign o_out_channel  = r_ch;

endmodule

// ===== rtl/avgp_ctrl.sv =====
module avgp_ctrl import avgp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_DIV_START,
        S_DIV_WAIT,
        S_SCALE
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = i_sts.emit ? S_DIV_START : S_IDLE;
            end
            S_DIV_START: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) n_state = S_SCALE;
            end
            S_SCALE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    assign o_ready         = (r_state == S_IDLE);
    assign o_cmd.load_in   = (r_state == S_IDLE) && i_valid;
    assign o_cmd.mem_rd    = (r_state == S_READ);
    assign o_cmd.update    = (r_state == S_UPDATE);
    assign o_cmd.div_start = (r_state == S_DIV_START);
    assign o_cmd.out_load  = (r_state == S_SCALE) && i_sts.out_free;

endmodule

// ===== rtl/avg_pool_1d_fixed_point_unit.sv =====
// Streaming 1-D average pooling over signed fixed-point samples that arrive sample-major
// with the channel index innermost. Each request updates that channel's running window
// sum and sample history; when it completes a window (at the sample whose index is one
// less than the window length, and every window step samples after that) one result
// follows: the sum, optionally clamped at zero, divided by the window length toward zero,
// shifted by scale_shift (right when positive, left when negative) and saturated. A
// request that completes no window passes through the read and update states before the
// next is taken; one that completes a window also starts and waits for the bit-serial
// divider that produces one quotient bit per cycle. A finished result waits in
// an output register while the next request is taken; a result that finds that register
// still occupied holds the block until the receiver takes the older one. frame_start
// restarts all counters and window sums. Configuration is written through a plain write
// port, by the user only while the block is idle; the block does not enforce this.
module avg_pool_1d_fixed_point_unit import avgp_pkg::*; #(
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_POOL     = 16,
    parameter int DATA_WIDTH   = 16,
    parameter int ACC_WIDTH    = 32,
    localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_sample_value,
    input  logic                         i_frame_start,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_avg_value,
    output logic [15:0]                  o_out_position,
    output logic [CH_W-1:0]              o_out_channel
);

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count <= 7'd1;
            r_cfg.window_len    <= PW'(2);
            r_cfg.window_step   <= 8'd2;
            r_cfg.relu_enable   <= 1'b0;
            r_cfg.scale_shift   <= 6'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHANNEL_COUNT: r_cfg.channel_count <= i_cfg_data[6:0];
                CFG_WINDOW_LEN:    r_cfg.window_len    <= i_cfg_data[PW-1:0];
                CFG_WINDOW_STEP:   r_cfg.window_step   <= i_cfg_data[7:0];
                CFG_RELU_ENABLE:   r_cfg.relu_enable   <= i_cfg_data[0];
                CFG_SCALE_SHIFT:   r_cfg.scale_shift   <= $signed(i_cfg_data[5:0]);
                default: begin
                end
            endcase
        end
    end

    avgp_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    avgp_dp #(
        .MAX_CHANNELS(MAX_CHANNELS),
        .MAX_POOL    (MAX_POOL),
        .DATA_WIDTH  (DATA_WIDTH),
        .ACC_WIDTH   (ACC_WIDTH),
        .CH_W        (CH_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_sample_value(i_sample_value),
        .i_frame_start (i_frame_start),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_avg_value   (o_avg_value),
        .o_out_position(o_out_position),
        .o_out_channel (o_out_channel)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import avgp_pkg::*;

    localparam int     CLK_PERIOD    = 10;
    localparam int     RESET_CYCLES  = 7;
    localparam int     SETTLE_CYCLES = 60;
    localparam int     RANDOM_ITEMS  = 1300;
    localparam int     CYCLE_LIMIT   = 8_000_000;
    localparam longint SAMPLE_MAX    = 32767;
    localparam longint SAMPLE_MIN    = -32768;

    // one pooled value as the block reports it
    typedef struct packed {
        logic signed [15:0] avg;
        logic [15:0]        pos;
        logic [5:0]         ch;
    } t_pooled;

    // tracks the pooling state and checks each pooled value in order
    class t_scoreboard;
        logic [6:0]         reg_channels;
        logic [4:0]         reg_pool;
        logic [7:0]         reg_stride;
        logic               reg_relu;
        logic signed [5:0]  reg_shift;
        logic signed [15:0] history [0:1023];
        logic [31:0]        sums [0:63];
        int unsigned        chan_pos, sample_pos, hist_slot, stride_left, window_idx;
        t_pooled            awaited[$];
        int                 errors;

        function new();
            reg_channels = 7'd1;
            reg_pool     = 5'd2;
            reg_stride   = 8'd2;
            reg_relu     = 1'b0;
            reg_shift    = '0;
            foreach (history[i]) history[i] = '0;
            foreach (sums[i]) sums[i] = '0;
            chan_pos    = 0;
            sample_pos  = 0;
            hist_slot   = 0;
            stride_left = 0;
            window_idx  = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] data);
            case (idx)
                CFG_CHANNEL_COUNT: reg_channels = data[6:0];
                CFG_WINDOW_LEN:    reg_pool     = data[4:0];
                CFG_WINDOW_STEP:   reg_stride   = data;
                CFG_RELU_ENABLE:   reg_relu     = data[0];
                CFG_SCALE_SHIFT:   reg_shift    = data[5:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // update window state for one accepted request, queue the pooled value if any
        function void note_request(logic signed [15:0] sample, logic frame_start);
            int unsigned        n_ch, n_pool, stride, c, slot, hidx;
            logic signed [31:0] wide_in, wide_old;
            longint             acc;
            int                 sh;
            t_pooled            res;
            n_ch   = (reg_channels == 0) ? 1 : (reg_channels > 64) ? 64 : reg_channels;
            n_pool = (reg_pool == 0) ? 1 : (reg_pool > 16) ? 16 : reg_pool;
            stride = (reg_stride == 0) ? 1 : reg_stride;

            // new frame clears counters and sums
            if (frame_start) begin
                chan_pos    = 0;
                sample_pos  = 0;
                hist_slot   = 0;
                stride_left = 0;
                window_idx  = 0;
                foreach (sums[i]) sums[i] = '0;
            end

            // running sum: add newest, drop the one leaving the window
            c        = chan_pos % 64;
            slot     = hist_slot % 16;
            hidx     = c * 16 + slot;
            wide_in  = sample;
            wide_old = history[hidx];
            sums[c]  = sums[c] + wide_in;
            if (sample_pos >= n_pool)
                sums[c] = sums[c] - wide_old;
            history[hidx] = sample;

            // window complete: relu, divide, rescale, saturate
            if (sample_pos >= n_pool - 1 && stride_left == 0) begin
                acc = $signed(sums[c]);
                if (reg_relu && acc < 0)
                    acc = 0;
                acc = acc / longint'(n_pool);
                sh  = reg_shift;
                if (sh >= 0)
                    acc = acc >>> sh;
                else if (acc > (SAMPLE_MAX >>> -sh))
                    acc = SAMPLE_MAX;
                else if (acc < -((-SAMPLE_MIN) >>> -sh))
                    acc = SAMPLE_MIN;
                else
                    acc = acc <<< -sh;
                if (acc > SAMPLE_MAX)
                    acc = SAMPLE_MAX;
                else if (acc < SAMPLE_MIN)
                    acc = SAMPLE_MIN;
                res.avg = acc[15:0];
                res.pos = window_idx[15:0];
                res.ch  = c[5:0];
                awaited.push_back(res);
            end

            // advance channel, then sample-level counters at the last channel
            chan_pos = c + 1;
            if (chan_pos >= n_ch) begin
                chan_pos = 0;
                if (sample_pos >= n_pool - 1) begin
                    if (stride_left == 0) begin
                        stride_left = (stride - 1) & 8'hFF;
                        window_idx  = (window_idx + 1) & 16'hFFFF;
                    end else begin
                        stride_left--;
                    end
                end
                if (sample_pos < 65535)
                    sample_pos++;
                hist_slot = slot + 1;
                if (hist_slot >= n_pool)
                    hist_slot = 0;
            end
        endfunction

        // compare one accepted result with the oldest expected value
        function void check_result(logic signed [15:0] avg, logic [15:0] pos, logic [5:0] ch);
            t_pooled want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result avg_value %0d out_position %0d out_channel %0d",
                         $time, avg, pos, ch);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (avg !== want.avg) begin
                $display("%0t: avg_value mismatch, expected %0d, actual %0d",
                         $time, want.avg, avg);
                errors++;
            end
            if (pos !== want.pos) begin
                $display("%0t: out_position mismatch, expected %0d, actual %0d",
                         $time, want.pos, pos);
                errors++;
            end
            if (ch !== want.ch) begin
                $display("%0t: out_channel mismatch, expected %0d, actual %0d",
                         $time, want.ch, ch);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic signed [15:0]   i_sample_value;
    logic                 i_frame_start;
    logic                 o_valid;
    logic                 i_ready;
    logic signed [15:0]   o_avg_value;
    logic [15:0]          o_out_position;
    logic [5:0]           o_out_channel;

    t_scoreboard sb;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cycle_count = 0;

    avg_pool_1d_fixed_point_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_value (i_sample_value),
        .i_frame_start  (i_frame_start),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_avg_value    (o_avg_value),
        .o_out_position (o_out_position),
        .o_out_channel  (o_out_channel)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_avg_value, o_out_position, o_out_channel);
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one register write, upper bits sometimes filled with junk
    task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val, input int width);
        logic [7:0] mask;
        logic [7:0] data;
        mask = 8'((1 << width) - 1);
        data = val & mask;
        if ($urandom_range(3) == 0)
            data = data | (8'($urandom) & ~mask);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // program a setting; keep_shape leaves channel count and pool size alone
    task automatic apply_setting(input bit keep_shape, input logic [7:0] nch,
                                 input logic [7:0] pool, input logic [7:0] stride,
                                 input logic relu, input int shift);
        if (!keep_shape) begin
            cfg_write(CFG_CHANNEL_COUNT, nch, 7);
            cfg_write(CFG_WINDOW_LEN, pool, 5);
        end
        cfg_write(CFG_WINDOW_STEP, stride, 8);
        cfg_write(CFG_RELU_ENABLE, {7'd0, relu}, 1);
        cfg_write(CFG_SCALE_SHIFT, 8'(shift), 6);
        i_cfg_we <= 1'b0;
    endtask

    // present one request and hold it until taken
    task automatic send_sample(input logic signed [15:0] sample, input logic fs);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_value <= sample;
        i_frame_start  <= fs;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_request(sample, fs);
        @(negedge i_clk);
    endtask

    // stop requests, wait for all pooled values, let the divider finish
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 16'sh7FFF;
        if (r < 16)
            return 16'sh8000;
        if (r < 45)
            return 16'(int'($urandom_range(128)) - 64);
        return 16'($urandom);
    endfunction

    initial begin
        int          r, shift_v, n_samples, eff_ch, eff_pool, random_items;
        logic [7:0]  nch_v, pool_v, stride_v;
        logic        relu_v, fs;
        bit          keep_shape, started;

        sb             = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_sample_value = '0;
        i_frame_start  = 1'b0;
        i_ready        = 1'b0;
        send_idle_pct  = 17;
        recv_idle_pct  = 46;
        random_items   = 0;
        started        = 0;
        nch_v          = 8'd1;
        pool_v         = 8'd2;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // extremes at the reset-like setting, with a restart mid-frame
        apply_setting(0, 8'd1, 8'd2, 8'd2, 1'b0, 0);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh8000, 1'b0);

        // zero registers act as one, relu, a left shift of 31 saturates
        drain_results();
        apply_setting(0, 8'd0, 8'd1, 8'd0, 1'b1, -31);
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(-16'sd5, 1'b0);

        // zero pool acts as one, largest right shift, two channels
        drain_results();
        apply_setting(0, 8'd2, 8'd0, 8'd1, 1'b0, 31);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);

        // left shift overflow on a window, then a long stride
        drain_results();
        apply_setting(0, 8'd1, 8'd3, 8'd255, 1'b0, -1);
        send_sample(16'sd20000, 1'b1);
        send_sample(16'sd20000, 1'b0);
        send_sample(16'sd20000, 1'b0);
        send_sample(-16'sd20000, 1'b0);
        send_sample(-16'sd20000, 1'b0);
        send_sample(-16'sd20000, 1'b0);

        // random phases, each a fresh frame or a continued one with new scaling
        while (random_items < RANDOM_ITEMS) begin
            if (random_items < RANDOM_ITEMS / 3) begin
                send_idle_pct = 17;
                recv_idle_pct = 46;
            end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 46;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            keep_shape = started && ($urandom_range(3) == 0);

            if (!keep_shape) begin
                r = $urandom_range(99);
                if (r < 6)
                    nch_v = 8'd0;
                else if (r < 10)
                    nch_v = 8'd64;
                else if (r < 13)
                    nch_v = 8'($urandom_range(65, 127));
                else if (r < 25)
                    nch_v = 8'($urandom_range(5, 12));
                else
                    nch_v = 8'($urandom_range(1, 4));
                eff_ch = (nch_v == 0) ? 1 : (nch_v > 64) ? 64 : nch_v;
                r = $urandom_range(99);
                if (eff_ch > 8)
                    pool_v = 8'($urandom_range(1, 3));
                else if (r < 8)
                    pool_v = 8'd16;
                else if (r < 12)
                    pool_v = 8'd0;
                else if (r < 18)
                    pool_v = 8'($urandom_range(17, 31));
                else
                    pool_v = 8'($urandom_range(1, 5));
            end

            r = $urandom_range(99);
            if (r < 8)
                stride_v = 8'd0;
            else if (r < 14)
                stride_v = 8'd255;
            else if (r < 20)
                stride_v = 8'($urandom_range(4, 254));
            else
                stride_v = 8'($urandom_range(1, 3));
            relu_v = $urandom_range(1);
            r = $urandom_range(99);
            if (r < 10)
                shift_v = -31;
            else if (r < 20)
                shift_v = 31;
            else if (r < 45)
                shift_v = int'($urandom_range(62)) - 31;
            else
                shift_v = int'($urandom_range(6)) - 3;

            drain_results();
            apply_setting(keep_shape, nch_v, pool_v, stride_v, relu_v, shift_v);

            eff_ch    = (nch_v == 0) ? 1 : (nch_v > 64) ? 64 : nch_v;
            eff_pool  = (pool_v == 0) ? 1 : (pool_v > 16) ? 16 : pool_v;
            n_samples = eff_pool + $urandom_range(0, (eff_ch > 8) ? 3 : 10);
            for (int s = 0; s < n_samples; s++) begin
                for (int c = 0; c < eff_ch; c++) begin
                    // frame opens the phase; stray restarts land anywhere
                    fs = (s == 0 && c == 0 && !keep_shape) || ($urandom_range(49) == 0);
                    send_sample(pick_sample(), fs);
                    random_items++;
                end
            end
            started = 1;
        end

        drain_results();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
